// File: rtl/core/rfbd_pkg.sv
package rfbd_pkg;

  localparam int FieldLimitDefault  = 15;
  localparam int ValueBitsDefault   = 31;
  localparam int PositionBitsDefault = 32;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int CharCntW   = 5;
  localparam int LengthW    = 32;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic [1:0] KindInline = 2'd0;
  localparam logic [1:0] KindArray  = 2'd1;
  localparam logic [1:0] KindOther  = 2'd2;

  localparam logic [2:0] ErrNone        = 3'd0;
  localparam logic [2:0] ErrCountLong   = 3'd1;
  localparam logic [2:0] ErrCountNotPos = 3'd2;
  localparam logic [2:0] ErrNoDollar    = 3'd3;
  localparam logic [2:0] ErrLenLong     = 3'd4;
  localparam logic [2:0] ErrNegLen      = 3'd5;
  localparam logic [2:0] ErrPayload     = 3'd6;

  typedef enum logic [2:0] {
    PhStart,
    PhLine,
    PhCount,
    PhDollar,
    PhLen,
    PhPayload,
    PhPayCr,
    PhPayLf
  } phase_e;

  typedef enum logic [1:0] {
    NumSkip,
    NumDigits,
    NumStop
  } num_phase_e;

  typedef struct packed {
    logic       is_cr;
    logic       is_lf;
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_plus;
    logic       is_minus;
    logic       is_star;
    logic       is_dollar;
    logic       is_type;
  } cls_t;

endpackage

// File: rtl/core/rfbd_classify.sv
module rfbd_classify (
  input  logic          [7:0] data_byte_i,
  output rfbd_pkg::cls_t      cls_o
);
  import rfbd_pkg::*;

  logic [7:0] digit_off;

  assign digit_off = data_byte_i - ChZero;

  always_comb begin
    cls_o.is_cr     = (data_byte_i == ChCr);
    cls_o.is_lf     = (data_byte_i == ChLf);
    cls_o.is_space  = (data_byte_i == ChSpace) || (data_byte_i >= ChTab && data_byte_i <= ChCr);
    cls_o.is_digit  = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
    cls_o.digit     = digit_off[3:0];
    cls_o.is_plus   = (data_byte_i == ChPlus);
    cls_o.is_minus  = (data_byte_i == ChMinus);
    cls_o.is_star   = (data_byte_i == ChStar);
    cls_o.is_dollar = (data_byte_i == ChDollar);
    cls_o.is_type   = (data_byte_i == ChDollar) || (data_byte_i == ChPlus) ||
                      (data_byte_i == ChMinus) || (data_byte_i == ChColon);
  end

endmodule

// File: rtl/core/rfbd_queue.sv
module rfbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfbd_pkg::cls_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rfbd_pkg::cls_t pop_data_o
);
  import rfbd_pkg::*;

  cls_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o     = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/rfbd_framer.sv
module rfbd_framer #(
  parameter int FIELD_LIMIT   = rfbd_pkg::FieldLimitDefault,
  parameter int VALUE_BITS    = rfbd_pkg::ValueBitsDefault,
  parameter int POSITION_BITS = rfbd_pkg::PositionBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cls_valid_i,
  input  rfbd_pkg::cls_t                  cls_i,
  output logic                            cls_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            frame_done_o,
  output logic [rfbd_pkg::LengthW-1:0]    frame_length_o,
  output logic [1:0]                      frame_kind_o,
  output logic [2:0]                      error_code_o
);
  import rfbd_pkg::*;

  localparam int LenExtW = (POSITION_BITS > LengthW) ? POSITION_BITS : LengthW;
  localparam logic [CharCntW-1:0] Limit = CharCntW'(FIELD_LIMIT);

  phase_e                   phase_q, phase_d;
  logic                     prev_cr_q, prev_cr_d;
  logic [CharCntW-1:0]      chars_q, chars_d;
  num_phase_e               nph_q, nph_d;
  logic                     neg_q, neg_d;
  logic [VALUE_BITS-1:0]    val_q, val_d;
  logic [VALUE_BITS-1:0]    elem_q, elem_d;
  logic [VALUE_BITS-1:0]    pay_q, pay_d;
  logic [POSITION_BITS-1:0] seen_q, seen_d;
  logic [1:0]               kind_q, kind_d;

  logic                     out_valid_q;
  logic                     done_q;
  logic [LengthW-1:0]       length_q;
  logic [1:0]               okind_q;
  logic [2:0]               err_q;

  logic                     take;
  logic                     cr_pending, field_end, long_a, long_b, apply_b, too_long;
  logic [CharCntW-1:0]      chars_a, chars_b;
  num_phase_e               nph_a, nph_f;
  logic                     neg_f;
  logic [VALUE_BITS-1:0]    val_f, val_new;
  logic [VALUE_BITS+3:0]    val_x10;
  logic                     done;
  logic [2:0]               err;
  logic [LenExtW-1:0]       seen_ext;

  assign take      = cls_valid_i && (!out_valid_q || !out_stall_i);
  assign cls_pop_o = take;

  always_comb begin
    val_x10 = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) + (VALUE_BITS+4)'(cls_i.digit);
    val_new = (|val_x10[VALUE_BITS+3:VALUE_BITS]) ? '1 : val_x10[VALUE_BITS-1:0];

    cr_pending = prev_cr_q && !cls_i.is_lf;
    field_end  = prev_cr_q && cls_i.is_lf;
    chars_a    = chars_q + CharCntW'(cr_pending);
    nph_a      = (cr_pending && nph_q != NumSkip) ? NumStop : nph_q;
    long_a     = cr_pending && (chars_a > Limit);
    apply_b    = !field_end && !cls_i.is_cr && !long_a;
    chars_b    = chars_a + CharCntW'(apply_b);
    long_b     = apply_b && (chars_b > Limit);
    too_long   = long_a || long_b;

    nph_f = nph_a;
    neg_f = neg_q;
    val_f = val_q;
    if (apply_b && !long_b) begin
      if (nph_a == NumSkip && cls_i.is_space) begin
        nph_f = nph_a;
      end else if (nph_a == NumSkip && (cls_i.is_plus || cls_i.is_minus)) begin
        neg_f = cls_i.is_minus;
        nph_f = NumDigits;
      end else if (nph_a != NumStop && cls_i.is_digit) begin
        val_f = val_new;
        nph_f = NumDigits;
      end else begin
        nph_f = NumStop;
      end
    end
  end

  always_comb begin
    done = 1'b0;
    err  = ErrNone;
    case (phase_q)
      PhLine: begin
        done = prev_cr_q && cls_i.is_lf;
      end
      PhCount: begin
        if (too_long) begin
          err = ErrCountLong;
        end else if (field_end && (neg_q || val_q == '0)) begin
          err = ErrCountNotPos;
        end
      end
      PhDollar: begin
        if (!cls_i.is_dollar) begin
          err = ErrNoDollar;
        end
      end
      PhLen: begin
        if (too_long) begin
          err = ErrLenLong;
        end else if (field_end && neg_q && val_q != '0) begin
          err = ErrNegLen;
        end
      end
      PhPayCr: begin
        if (!cls_i.is_cr) begin
          err = ErrPayload;
        end
      end
      PhPayLf: begin
        if (!cls_i.is_lf) begin
          err = ErrPayload;
        end else begin
          done = (elem_q == VALUE_BITS'(1));
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhStart: begin
        phase_d = cls_i.is_star ? PhCount : PhLine;
      end
      PhLine: begin
        phase_d = PhLine;
      end
      PhCount: begin
        if (field_end) begin
          phase_d = PhDollar;
        end
      end
      PhDollar: begin
        phase_d = PhLen;
      end
      PhLen: begin
        if (field_end) begin
          phase_d = (val_q == '0) ? PhPayCr : PhPayload;
        end
      end
      PhPayload: begin
        if (pay_q == VALUE_BITS'(1)) begin
          phase_d = PhPayCr;
        end
      end
      PhPayCr: begin
        phase_d = PhPayLf;
      end
      PhPayLf: begin
        phase_d = PhDollar;
      end
      default: begin
        phase_d = PhStart;
      end
    endcase
    if (done || err != ErrNone) begin
      phase_d = PhStart;
    end
  end

  always_comb begin
    prev_cr_d = prev_cr_q;
    chars_d   = chars_q;
    nph_d     = nph_q;
    neg_d     = neg_q;
    val_d     = val_q;
    elem_d    = elem_q;
    pay_d     = pay_q;
    kind_d    = kind_q;
    seen_d    = (seen_q != '1) ? seen_q + 1'b1 : seen_q;
    case (phase_q)
      PhStart: begin
        seen_d    = POSITION_BITS'(1);
        prev_cr_d = cls_i.is_cr && !cls_i.is_star;
        chars_d   = '0;
        nph_d     = NumSkip;
        neg_d     = 1'b0;
        val_d     = '0;
        if (cls_i.is_star) begin
          kind_d = KindArray;
        end else begin
          kind_d = cls_i.is_type ? KindOther : KindInline;
        end
      end
      PhLine: begin
        prev_cr_d = cls_i.is_cr;
      end
      PhCount: begin
        prev_cr_d = cls_i.is_cr;
        chars_d   = chars_b;
        nph_d     = nph_f;
        neg_d     = neg_f;
        val_d     = val_f;
        if (field_end) begin
          elem_d = val_q;
        end
      end
      PhDollar: begin
        prev_cr_d = 1'b0;
        chars_d   = '0;
        nph_d     = NumSkip;
        neg_d     = 1'b0;
        val_d     = '0;
      end
      PhLen: begin
        prev_cr_d = cls_i.is_cr;
        chars_d   = chars_b;
        nph_d     = nph_f;
        neg_d     = neg_f;
        val_d     = val_f;
        if (field_end) begin
          pay_d = val_q;
        end
      end
      PhPayload: begin
        pay_d = pay_q - 1'b1;
      end
      PhPayLf: begin
        if (cls_i.is_lf) begin
          elem_d = elem_q - 1'b1;
        end
      end
      default: begin
        pay_d = pay_q;
      end
    endcase
    if (done || err != ErrNone) begin
      prev_cr_d = 1'b0;
    end
  end

  assign seen_ext = LenExtW'(seen_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      prev_cr_q   <= 1'b0;
      chars_q     <= '0;
      nph_q       <= NumSkip;
      neg_q       <= 1'b0;
      val_q       <= '0;
      elem_q      <= '0;
      pay_q       <= '0;
      seen_q      <= '0;
      kind_q      <= KindInline;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q   <= phase_d;
        prev_cr_q <= prev_cr_d;
        chars_q   <= chars_d;
        nph_q     <= nph_d;
        neg_q     <= neg_d;
        val_q     <= val_d;
        elem_q    <= elem_d;
        pay_q     <= pay_d;
        seen_q    <= seen_d;
        kind_q    <= kind_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      done_q   <= done;
      length_q <= done ? seen_ext[LengthW-1:0] : '0;
      okind_q  <= kind_d;
      err_q    <= err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_done_o   = done_q;
  assign frame_length_o = length_q;
  assign frame_kind_o   = okind_q;
  assign error_code_o   = err_q;

endmodule

// File: rtl/core/resp_frame_boundary_detector.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   data_byte_i
// output    out        out_valid_o/out_stall_i frame_done_o, frame_length_o,
//                                              frame_kind_o, error_code_o
//
// One byte is taken per clock while in_stall_o is low, and one result is produced per byte.
// A byte is first written into the queue; the framer then takes it from the queue and registers
// its result in the output register.
// The reset is asynchronous and clears the queue and all frame state; no clearing pass.
// A four-entry queue between the classifier and the framer absorbs output stalls;
// in_stall_o rises only when that queue is full.
module resp_frame_boundary_detector #(
  parameter int FIELD_LIMIT   = rfbd_pkg::FieldLimitDefault,
  parameter int VALUE_BITS    = rfbd_pkg::ValueBitsDefault,
  parameter int POSITION_BITS = rfbd_pkg::PositionBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         frame_done_o,
  output logic [rfbd_pkg::LengthW-1:0] frame_length_o,
  output logic [1:0]                   frame_kind_o,
  output logic [2:0]                   error_code_o
);
  import rfbd_pkg::*;

  cls_t cls_in;
  cls_t cls_out;
  logic q_full, q_empty, q_pop;

  rfbd_classify u_classify (
    .data_byte_i (data_byte_i),
    .cls_o       (cls_in)
  );

  rfbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (cls_out)
  );

  rfbd_framer #(
    .FIELD_LIMIT   (FIELD_LIMIT),
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cls_valid_i    (!q_empty),
    .cls_i          (cls_out),
    .cls_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_done_o   (frame_done_o),
    .frame_length_o (frame_length_o),
    .frame_kind_o   (frame_kind_o),
    .error_code_o   (error_code_o)
  );

  assign in_stall_o = q_full;

endmodule
